FILE: sv/sap_pkg.sv
package sap_pkg;

  // Default angle resolution: 4096 codes per turn
  localparam int unsigned ANGLE_BITS_DEF = 12;

  // Fixed widths of state and result fields
  localparam int unsigned TOGGLE_W = 19;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Toggles for one full turn (1600 steps, a rise and a fall per step, times 200)
  localparam int unsigned TPT_W = 20;
  localparam logic [TPT_W-1:0] TOGGLES_PER_TURN = TPT_W'(640000);

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_TOL    = 2'd1,
    CFG_SLOW   = 2'd2,
    CFG_FAST   = 2'd3
  } cfg_idx_e;

  // Kind of command handed from front to back
  typedef enum logic [1:0] {
    K_TICK = 2'd0,
    K_HOLD = 2'd1,
    K_MOVE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic                dir;
    logic [TOGGLE_W-1:0] toggles;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

endpackage

FILE: sv/sap_in_if.sv
interface sap_in_if import sap_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [ANGLE_BITS-1:0] measured_angle;

  modport source (output valid, output mode, output measured_angle, input ready);
  modport sink   (input valid, input mode, input measured_angle, output ready);
endinterface

FILE: sv/sap_out_if.sv
interface sap_out_if import sap_pkg::*;;
  logic                valid;
  logic                ready;
  logic                direction;
  logic                pulse_level;
  logic [TOGGLE_W-1:0] toggles_left;
  logic                settled;

  modport source (output valid, output direction, output pulse_level,
                  output toggles_left, output settled, input ready);
  modport sink   (input valid, input direction, input pulse_level,
                  input toggles_left, input settled, output ready);
endinterface

FILE: sv/sap_front.sv
module sap_front import sap_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ANGLE_BITS-1:0] cfg_data_i,
  sap_in_if.sink                in_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  input  logic                  full_i
);

  localparam int unsigned EW  = ANGLE_BITS + 2;
  localparam int unsigned PW  = ANGLE_BITS + 10;
  localparam int unsigned MW  = ANGLE_BITS + TPT_W;
  localparam logic signed [EW-1:0] HALF_S = EW'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [EW-1:0] TURN_S = EW'(2 ** ANGLE_BITS);
  localparam logic signed [PW-1:0] RND_S  = PW'(2 ** ANGLE_BITS - 1);

  // Configuration registers
  logic [ANGLE_BITS-1:0] tgt_q, tol_q;
  logic [SPEED_W-1:0]    slow_q, fast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= '0;
      tol_q  <= ANGLE_BITS'(11);
      slow_q <= SPEED_W'(10);
      fast_q <= SPEED_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET: tgt_q  <= cfg_data_i;
        CFG_TOL:    tol_q  <= cfg_data_i;
        CFG_SLOW:   slow_q <= cfg_data_i[SPEED_W-1:0];
        CFG_FAST:   fast_q <= cfg_data_i[SPEED_W-1:0];
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when it drains
  logic v1_q, v2_q;
  logic en1, en2;

  assign push_o     = v2_q && !full_i;
  assign en2        = !v2_q || !full_i;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;

  // Stage 1: wrapped error, magnitude, tolerance check
  logic signed [EW-1:0] diff_s, err_s, mag_s;
  logic [ANGLE_BITS-1:0] mag;

  always_comb begin
    diff_s = $signed({2'b00, tgt_q}) - $signed({2'b00, in_i.measured_angle});
    if (diff_s > HALF_S) begin
      err_s = diff_s - TURN_S;
    end else if (diff_s < -HALF_S) begin
      err_s = diff_s + TURN_S;
    end else begin
      err_s = diff_s;
    end
    mag_s = (err_s < 0) ? -err_s : err_s;
    mag   = mag_s[ANGLE_BITS-1:0];
  end

  logic                         mode1_q, within1_q;
  logic signed [ANGLE_BITS:0]   err1_q;
  logic [ANGLE_BITS-1:0]        mag1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q   <= in_i.mode;
      err1_q    <= err_s[ANGLE_BITS:0];
      mag1_q    <= mag;
      within1_q <= (mag <= tol_q);
    end
  end

  // Stage 2: step count and period products
  logic signed [SPEED_W:0] dlt_s;
  logic [MW-1:0]           tog_prod_d;
  logic signed [PW-1:0]    per_prod_d;

  assign dlt_s      = $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
  assign tog_prod_d = MW'(mag1_q) * MW'(TOGGLES_PER_TURN);
  assign per_prod_d = PW'(dlt_s) * PW'(err1_q);

  logic                 mode2_q, within2_q, dir2_q;
  logic [MW-1:0]        tog_prod_q;
  logic signed [PW-1:0] per_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mode2_q    <= mode1_q;
      within2_q  <= within1_q;
      dir2_q     <= (err1_q > 0);
      tog_prod_q <= tog_prod_d;
      per_prod_q <= per_prod_d;
    end
  end

  // Quotient truncated toward zero, period saturated at zero
  logic signed [PW-1:0]   per_adj_s;
  logic signed [10:0]     quo_s, per_s;

  always_comb begin
    per_adj_s = (per_prod_q < 0) ? (per_prod_q + RND_S) : per_prod_q;
    quo_s     = 11'(per_adj_s >>> ANGLE_BITS);
    per_s     = $signed({3'b000, slow_q}) + quo_s;

    cmd_o.dir     = dir2_q;
    cmd_o.toggles = tog_prod_q[ANGLE_BITS+TOGGLE_W-1:ANGLE_BITS];
    cmd_o.period  = (per_s < 0) ? '0 : per_s[PERIOD_W-1:0];
    if (!mode2_q) begin
      cmd_o.kind = K_TICK;
    end else if (within2_q) begin
      cmd_o.kind = K_HOLD;
    end else begin
      cmd_o.kind = K_MOVE;
    end
  end

  // A stage-2 item blocked by a full queue stays put
  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && full_i) |=> v2_q)
    else $error("front dropped a blocked item");

endmodule

FILE: sv/sap_queue.sv
module sap_queue import sap_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/sap_back.sv
module sap_back import sap_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  input  logic     empty_i,
  output logic     pop_o,
  sap_out_if.source out_o
);

  logic                rem_zero;
  logic [TOGGLE_W-1:0] rem_q;
  logic                dir_q, pulse_q, ov_q;
  logic [PERIOD_W-1:0] per_q, div_q, div_inc;

  // Take the next command once the result slot is free or being taken
  assign pop_o    = !empty_i && (!ov_q || out_o.ready);
  assign rem_zero = (rem_q == '0);
  assign div_inc  = div_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      rem_q   <= '0;
      dir_q   <= 1'b0;
      pulse_q <= 1'b0;
      per_q   <= '0;
      div_q   <= '0;
    end else begin
      if (pop_o) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (pop_o) begin
        unique case (cmd_i.kind)
          K_TICK: begin
            if (!rem_zero) begin
              if (div_inc >= per_q) begin
                div_q   <= '0;
                pulse_q <= ~pulse_q;
                rem_q   <= rem_q - 1'b1;
              end else begin
                div_q <= div_inc;
              end
            end
          end
          K_HOLD: begin
            rem_q <= '0;
            dir_q <= 1'b0;
          end
          K_MOVE: begin
            rem_q <= cmd_i.toggles;
            dir_q <= cmd_i.dir;
            per_q <= cmd_i.period;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result is the state after the update
  assign out_o.valid        = ov_q;
  assign out_o.direction    = dir_q;
  assign out_o.pulse_level  = pulse_q;
  assign out_o.toggles_left = rem_q;
  assign out_o.settled      = rem_zero;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> ($stable(rem_q) && $stable(pulse_q) && $stable(dir_q)))
    else $error("state moved under a stalled result");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.kind == K_TICK) |=>
      (rem_q == $past(rem_q) || rem_q == $past(rem_q) - 1'b1))
    else $error("tick changed toggle count by more than one");

endmodule

FILE: sv/stepper_angle_positioner.sv
// Stepper angle positioner: position loop with step pulse generation.
// An item passes front stages 1 and 2, the queue and the back-end registers.
// Throughput: one item per cycle while out_o.ready is high; two front stages
// and a 4-entry queue feed the back end's state update and result register.
// Reset (rst_ni, async, active low) clears the valid flags and back-end state,
// empties the queue, loads register defaults; ready at once, no clearing pass.
module stepper_angle_positioner import sap_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned DEPTH      = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ANGLE_BITS-1:0] cfg_data_i,
  sap_in_if.sink                in_i,
  sap_out_if.source             out_o
);

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  // Front: config, error and command build
  sap_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full)
  );

  // Queue between front and back
  sap_queue #(.DEPTH(DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  // Back: motion state and result
  sap_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_out),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
